/* hw/rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation matrix to quaternion unit
// Holds the fixed-point format, the derived datapath widths, the branch code and
// the item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int M_W       = 16;
	localparam int T_W       = M_W + 2;
	localparam int MAG_W     = M_W + 1;
	localparam int ARG_W     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
	localparam int N_W       = ARG_W + FRAC_BITS + ((ARG_W + FRAC_BITS) % 2);
	localparam int R_W       = N_W / 2;
	localparam int Q_BITS    = M_W + 1;
	localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
	localparam int D_W       = R_W + 1;
	localparam int CMP_W     = (NUM_W > D_W + Q_BITS) ? NUM_W : D_W + Q_BITS;
	localparam int Q_DEPTH   = 2;
	localparam int PIPE_LAT  = R_W + Q_BITS + 5;

	localparam logic signed [M_W-1:0] SAT_MAX = {1'b0, {(M_W-1){1'b1}}};
	localparam logic signed [M_W-1:0] SAT_MIN = {1'b1, {(M_W-1){1'b0}}};

	typedef enum logic [1:0] {
		BR_X = 2'd0,
		BR_Y = 2'd1,
		BR_Z = 2'd2,
		BR_W = 2'd3
	} branch_t;

	typedef struct packed {
		branch_t                 br;
		logic [ARG_W-1:0]        arg;
		logic [2:0][T_W-1:0]     lane;
	} item_t;

	// Saturate a signed quotient given as sign, overflow flag and magnitude.
	function automatic logic [M_W-1:0] sat_quot(input logic neg, input logic ovf,
			input logic [Q_BITS-1:0] q);
		logic [Q_BITS-1:0] lim_pos;
		logic [Q_BITS-1:0] lim_neg;
		logic [Q_BITS-1:0] negq;
		lim_pos = Q_BITS'(SAT_MAX);
		lim_neg = lim_pos + Q_BITS'(1);
		negq    = ~q + Q_BITS'(1);
		if (!neg) begin
			sat_quot = (ovf || q > lim_pos) ? SAT_MAX : q[M_W-1:0];
		end else begin
			sat_quot = (ovf || q > lim_neg) ? SAT_MIN : negq[M_W-1:0];
		end
	endfunction

endpackage

/* hw/rtl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front: branch selection and term formation
// Picks the trace or diagonal branch, forms the clamped square-root argument
// and the three sum or difference terms, and registers the classified item.
// ----------------------------------------------------------------------------
module rmq_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic signed [rmq_pkg::M_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                       item_valid_s1,
	output rmq_pkg::item_t             item_s1
);
	import rmq_pkg::*;

	localparam int S_W = ARG_W + 1;

	logic signed [S_W-1:0] one, e00, e11, e22, a_tr, a_sel;
	logic signed [T_W-1:0] x01, x02, x10, x12, x20, x21;
	item_t item_d;

	always_comb begin
		one = S_W'(1) <<< FRAC_BITS;
		e00 = S_W'(m00);
		e11 = S_W'(m11);
		e22 = S_W'(m22);
		x01 = T_W'(m01);
		x02 = T_W'(m02);
		x10 = T_W'(m10);
		x12 = T_W'(m12);
		x20 = T_W'(m20);
		x21 = T_W'(m21);
		a_tr = one + e00 + e11 + e22;
		priority if (a_tr > 0) begin
			item_d.br = BR_W;
			a_sel     = a_tr;
			item_d.lane[0] = x21 - x12;
			item_d.lane[1] = x02 - x20;
			item_d.lane[2] = x10 - x01;
		end else if (m00 > m11 && m00 > m22) begin
			item_d.br = BR_X;
			a_sel     = one + e00 - e11 - e22;
			item_d.lane[0] = x01 + x10;
			item_d.lane[1] = x02 + x20;
			item_d.lane[2] = x21 - x12;
		end else if (m11 > m22) begin
			item_d.br = BR_Y;
			a_sel     = one - e00 + e11 - e22;
			item_d.lane[0] = x01 + x10;
			item_d.lane[1] = x12 + x21;
			item_d.lane[2] = x02 - x20;
		end else begin
			item_d.br = BR_Z;
			a_sel     = one - e00 - e11 + e22;
			item_d.lane[0] = x02 + x20;
			item_d.lane[1] = x12 + x21;
			item_d.lane[2] = x10 - x01;
		end
		// An argument at or below zero is clamped to one LSB.
		item_d.arg = (a_sel > 0) ? a_sel[ARG_W-1:0] : ARG_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_d;
	end

endmodule

/* hw/rtl/rmq_queue.sv */
// ----------------------------------------------------------------------------
// rmq_queue: short queue between front end and back end
// A two-entry first-in first-out store of classified items.
// ----------------------------------------------------------------------------
module rmq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rmq_pkg::item_t  push_item,
	input  logic            pop,
	output logic            empty,
	output logic            full,
	output rmq_pkg::item_t  head
);
	import rmq_pkg::*;

	localparam int P_W = $clog2(Q_DEPTH);

	item_t               mem_q [Q_DEPTH];
	logic [P_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [P_W:0]        count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (P_W+1)'(Q_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == P_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + P_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == P_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + P_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (P_W+1)'(1);
				2'b01:   count_q <= count_q - (P_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hw/rtl/rmq_back.sv */
// ----------------------------------------------------------------------------
// rmq_back: square root and scaling pipeline
// A bit-per-stage square root, then three bit-per-stage restoring dividers,
// then rounding, saturation and placement of the four components.
// ----------------------------------------------------------------------------
module rmq_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  rmq_pkg::item_t          in_item,
	output logic                    done,
	output logic [rmq_pkg::M_W-1:0] quat_x,
	output logic [rmq_pkg::M_W-1:0] quat_y,
	output logic [rmq_pkg::M_W-1:0] quat_z,
	output logic [rmq_pkg::M_W-1:0] quat_w
);
	import rmq_pkg::*;

	// Square-root stages.
	logic                  sq_v_s   [R_W+1];
	logic [N_W-1:0]        sq_n_s   [R_W+1];
	logic [N_W-1:0]        sq_res_s [R_W+1];
	branch_t               sq_br_s  [R_W+1];
	logic [2:0][T_W-1:0]   sq_ln_s  [R_W+1];

	// Divider stages.
	logic                  dv_v_s   [Q_BITS+1];
	branch_t               dv_br_s  [Q_BITS+1];
	logic [R_W-1:0]        dv_r_s   [Q_BITS+1];
	logic [2:0]            dv_neg_s [Q_BITS+1];
	logic [2:0]            dv_ovf_s [Q_BITS+1];
	logic [2:0][NUM_W-1:0] dv_rem_s [Q_BITS+1];
	logic [2:0][Q_BITS-1:0] dv_q_s  [Q_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else begin
			sq_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sq_n_s[0]   <= N_W'(in_item.arg) << FRAC_BITS;
		sq_res_s[0] <= '0;
		sq_br_s[0]  <= in_item.br;
		sq_ln_s[0]  <= in_item.lane;
	end

	for (genvar g = 0; g < R_W; g++) begin : g_sqrt
		localparam logic [N_W-1:0] BIT = N_W'(1) << (2 * (R_W - 1 - g));
		logic [N_W-1:0] trial;
		assign trial = sq_res_s[g] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[g+1] <= 1'b0;
			end else begin
				sq_v_s[g+1] <= sq_v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (sq_n_s[g] >= trial) begin
				sq_n_s[g+1]   <= sq_n_s[g] - trial;
				sq_res_s[g+1] <= (sq_res_s[g] >> 1) + BIT;
			end else begin
				sq_n_s[g+1]   <= sq_n_s[g];
				sq_res_s[g+1] <= sq_res_s[g] >> 1;
			end
			sq_br_s[g+1] <= sq_br_s[g];
			sq_ln_s[g+1] <= sq_ln_s[g];
		end
	end

	// Divider set-up: numerator (|t| << FRAC_BITS) + r over 2r gives rounding.
	logic [R_W-1:0] root;
	assign root = sq_res_s[R_W][R_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= sq_v_s[R_W];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_setup
		logic signed [T_W-1:0] t;
		logic [MAG_W-1:0]      mag;
		logic [NUM_W-1:0]      num;
		assign t   = $signed(sq_ln_s[R_W][l]);
		assign mag = (t < 0) ? MAG_W'(-t) : MAG_W'(t);
		assign num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(root);

		always_ff @(posedge clk) begin
			dv_neg_s[0][l] <= t < 0;
			dv_ovf_s[0][l] <= CMP_W'(num) >= (CMP_W'({root, 1'b0}) << Q_BITS);
			dv_rem_s[0][l] <= num;
			dv_q_s[0][l]   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		dv_br_s[0] <= sq_br_s[R_W];
		dv_r_s[0]  <= root;
	end

	for (genvar g = 0; g < Q_BITS; g++) begin : g_div
		localparam int K = Q_BITS - 1 - g;
		logic [CMP_W-1:0] dsh;
		assign dsh = CMP_W'({dv_r_s[g], 1'b0}) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[g+1] <= 1'b0;
			end else begin
				dv_v_s[g+1] <= dv_v_s[g];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (CMP_W'(dv_rem_s[g][l]) >= dsh) begin
					dv_rem_s[g+1][l]  <= dv_rem_s[g][l] - dsh[NUM_W-1:0];
					dv_q_s[g+1][l]    <= dv_q_s[g][l] | (Q_BITS'(1) << K);
				end else begin
					dv_rem_s[g+1][l]  <= dv_rem_s[g][l];
					dv_q_s[g+1][l]    <= dv_q_s[g][l];
				end
			end
		end

		always_ff @(posedge clk) begin
			dv_br_s[g+1]  <= dv_br_s[g];
			dv_r_s[g+1]   <= dv_r_s[g];
			dv_neg_s[g+1] <= dv_neg_s[g];
			dv_ovf_s[g+1] <= dv_ovf_s[g];
		end
	end

	// Output stage: the branch's own component is r/2 rounded half up.
	logic [R_W:0]             own_full;
	logic [M_W-1:0]           own;
	logic [2:0][M_W-1:0]      lq;
	logic [3:0][M_W-1:0]      comp;
	branch_t                  br_f;

	assign br_f     = dv_br_s[Q_BITS];
	assign own_full = ((R_W+1)'(dv_r_s[Q_BITS]) + (R_W+1)'(1)) >> 1;
	assign own      = (own_full > (R_W+1)'(SAT_MAX)) ? SAT_MAX : own_full[M_W-1:0];

	for (genvar l = 0; l < 3; l++) begin : g_sat
		assign lq[l] = sat_quot(dv_neg_s[Q_BITS][l], dv_ovf_s[Q_BITS][l],
				dv_q_s[Q_BITS][l]);
	end

	always_comb begin
		unique case (br_f)
			BR_X:    comp = {lq[2], lq[1], lq[0], own};
			BR_Y:    comp = {lq[2], lq[1], own, lq[0]};
			BR_Z:    comp = {lq[2], own, lq[1], lq[0]};
			default: comp = {own, lq[2], lq[1], lq[0]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v_s[Q_BITS];
		end
	end

	always_ff @(posedge clk) begin
		quat_x <= comp[0];
		quat_y <= comp[1];
		quat_z <= comp[2];
		quat_w <= comp[3];
	end

endmodule

/* hw/rtl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: Q1.14 rotation matrix to quaternion
// Front end selects the branch, a short queue decouples it from the back end,
// which takes the square root and scales the terms.
//
//   channel   handshake        payload
//   matrix    start / busy     m00 m01 m02 m10 m11 m12 m20 m21 m22
//   result    done (strobe)    quat_x quat_y quat_z quat_w
//
// One matrix may be accepted every cycle while busy is low; each Q1.14 result
// passes through the front-end register, the queue, the one-bit-per-stage
// square root, the divider set-up and dividers, and the output register.
// Reset clears all valid flags and the queue pointers; payload is not reset.
// Results cannot be held off; the back end never stalls, so busy only rises
// if the queue were to fill.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rmq_pkg::M_W-1:0]    m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                       done,
	output logic [rmq_pkg::M_W-1:0]    quat_x,
	output logic [rmq_pkg::M_W-1:0]    quat_y,
	output logic [rmq_pkg::M_W-1:0]    quat_z,
	output logic [rmq_pkg::M_W-1:0]    quat_w
);
	import rmq_pkg::*;

	logic  take, fr_valid, q_empty, q_full, q_pop;
	item_t fr_item, q_head;

	assign busy  = q_full;
	assign take  = start && !busy;
	assign q_pop = !q_empty;

	rmq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.m00           ($signed(m00)),
		.m01           ($signed(m01)),
		.m02           ($signed(m02)),
		.m10           ($signed(m10)),
		.m11           ($signed(m11)),
		.m12           ($signed(m12)),
		.m20           ($signed(m20)),
		.m21           ($signed(m21)),
		.m22           ($signed(m22)),
		.item_valid_s1 (fr_valid),
		.item_s1       (fr_item)
	);

	rmq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_valid),
		.push_item (fr_item),
		.pop       (q_pop),
		.empty     (q_empty),
		.full      (q_full),
		.head      (q_head)
	);

	rmq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_pop),
		.in_item  (q_head),
		.done     (done),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z),
		.quat_w   (quat_w)
	);

endmodule

/* hw/rtl/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker: port-level checks for the quaternion unit
// Checks the fixed latency between accepted beats and result beats and the
// identity matrix case.
// ----------------------------------------------------------------------------
module rmq_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic [rmq_pkg::M_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	input logic                    done,
	input logic [rmq_pkg::M_W-1:0] quat_x,
	input logic [rmq_pkg::M_W-1:0] quat_y,
	input logic [rmq_pkg::M_W-1:0] quat_z,
	input logic [rmq_pkg::M_W-1:0] quat_w
);
	import rmq_pkg::*;

	logic acc, ident;
	assign acc   = start && !busy;
	assign ident = m00 == 16'h4000 && m11 == 16'h4000 && m22 == 16'h4000 &&
			m01 == '0 && m02 == '0 && m10 == '0 && m12 == '0 && m20 == '0 && m21 == '0;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##PIPE_LAT done)
		else $error("accepted beat produced no result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(arst_n, PIPE_LAT) |-> $past(acc, PIPE_LAT))
		else $error("result beat without a matching accepted beat");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		acc && ident |-> ##PIPE_LAT (quat_w == 16'h4000 && quat_x == '0 &&
			quat_y == '0 && quat_z == '0))
		else $error("identity matrix did not give the unit quaternion");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);
